// ----- hw/rtl/plbr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbr_pkg
// Shared constants for the PWM line bit receiver: config indices, widths,
// reset values.
// ----------------------------------------------------------------------------
package plbr_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned TMO_W      = 24;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BITPOS_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd2;

  localparam logic              ACTIVE_LEVEL_RST = 1'b1;
  localparam logic [HALF_W-1:0] HALF_BIT_RST     = 16'd12;
  localparam logic [TMO_W-1:0]  TIMEOUT_RST      = 24'd500000;

  localparam logic [BITPOS_W-1:0] BITPOS_MSB = 3'd7;
  localparam logic [BITPOS_W-1:0] BITPOS_LSB = 3'd0;

endpackage

// ----- hw/rtl/plbr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbr_in_if / plbr_out_if
// Valid/ready channels for line samples and received bytes.
// ----------------------------------------------------------------------------
interface plbr_in_if;
  logic valid;
  logic ready;
  logic line_level;

  modport source (output valid, output line_level, input ready);
  modport sink (input valid, input line_level, output ready);
endinterface

interface plbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       sync_lost;

  modport source (output valid, output rx_byte, output sync_lost, input ready);
  modport sink (input valid, input rx_byte, input sync_lost, output ready);
endinterface

// ----- hw/rtl/pwm_line_bit_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_line_bit_receiver
// Path: sample register, then result register.
// Throughput: one sample per cycle while the result side keeps up; the
//   sample register advances whenever the result register is free or taken.
// Reset: asynchronous, active low; clears control state and loads register
//   defaults, counter saturated, line taken as inactive.
// ----------------------------------------------------------------------------
module pwm_line_bit_receiver #(
  parameter int unsigned TICK_COUNT_WIDTH = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [plbr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [plbr_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  plbr_in_if.sink                          sample_i,
  plbr_out_if.source                       result_o
);
  import plbr_pkg::*;

  localparam int unsigned CntW = TICK_COUNT_WIDTH;
  localparam int unsigned CmpW = (CntW > TMO_W) ? CntW : TMO_W;

  // config
  logic              active_level_q;
  logic [HALF_W-1:0] half_bit_q;
  logic [TMO_W-1:0]  timeout_q;

  // sample stage
  logic s1_valid_q, s1_valid_d;
  logic s1_level_q;
  logic s1_fire, in_ready;

  // receiver state
  logic                was_active_q, was_active_d;
  logic [CntW-1:0]     elapsed_q, elapsed_d;
  logic [BYTE_W-1:0]   partial_q, partial_d;
  logic [BITPOS_W-1:0] bitpos_q, bitpos_d;
  logic                tflag_q, tflag_d;

  // result stage
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_lost_q, out_lost_d;

  logic              active, rise, fall, bit_one, byte_done, timeout_hit;
  logic [BYTE_W-1:0] partial_set;

  assign s1_fire  = s1_valid_q && (!out_valid_q || result_o.ready);
  assign in_ready = !s1_valid_q || s1_fire;
  assign sample_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_level_q <= ACTIVE_LEVEL_RST;
      half_bit_q     <= HALF_BIT_RST;
      timeout_q      <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACTIVE_LEVEL: active_level_q <= cfg_wdata_i[0];
        CFG_HALF_BIT:     half_bit_q     <= cfg_wdata_i[HALF_W-1:0];
        CFG_TIMEOUT:      timeout_q      <= cfg_wdata_i[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    active    = (s1_level_q == active_level_q);
    rise      = active && !was_active_q;
    fall      = !active && was_active_q;

    if (rise) begin
      elapsed_d = '0;
    end else if (elapsed_q != {CntW{1'b1}}) begin
      elapsed_d = elapsed_q + CntW'(1);
    end else begin
      elapsed_d = elapsed_q;
    end
    tflag_d = rise ? 1'b0 : tflag_q;

    bit_one = elapsed_d > CntW'(half_bit_q);
    partial_set = partial_q;
    partial_set[bitpos_q] = bit_one;

    byte_done   = fall && (bitpos_q == BITPOS_LSB);
    timeout_hit = !byte_done && !tflag_d && (CmpW'(elapsed_d) > CmpW'(timeout_q));

    partial_d    = fall ? partial_set : partial_q;
    bitpos_d     = fall ? (bitpos_q - BITPOS_W'(1)) : bitpos_q;
    was_active_d = active;
    out_byte_d   = partial_set;
    out_lost_d   = 1'b0;

    if (byte_done) begin
      partial_d = '0;
      bitpos_d  = BITPOS_MSB;
    end else if (timeout_hit) begin
      partial_d  = '0;
      bitpos_d   = BITPOS_MSB;
      tflag_d    = 1'b1;
      out_byte_d = '0;
      out_lost_d = 1'b1;
    end

    s1_valid_d  = (sample_i.valid && in_ready) ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
    out_valid_d = s1_fire ? (byte_done || timeout_hit) : (out_valid_q && !result_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      was_active_q <= 1'b0;
      elapsed_q    <= {CntW{1'b1}};
      partial_q    <= '0;
      bitpos_q     <= BITPOS_MSB;
      tflag_q      <= 1'b1;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        was_active_q <= was_active_d;
        elapsed_q    <= elapsed_d;
        partial_q    <= partial_d;
        bitpos_q     <= bitpos_d;
        tflag_q      <= tflag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && in_ready) begin
      s1_level_q <= sample_i.line_level;
    end
    if (s1_fire && (byte_done || timeout_hit)) begin
      out_byte_q <= out_byte_d;
      out_lost_q <= out_lost_d;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.rx_byte   = out_byte_q;
  assign result_o.sync_lost = out_lost_q;

`ifndef SYNTHESIS
  a_loss_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_lost_q) |-> (out_byte_q == '0))
    else $error("sync loss transfer carries nonzero byte");

  a_stall_holds_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (s1_valid_q && out_valid_q && !result_o.ready))
    else $error("sample side stalled without a blocked result");

  a_loss_resets_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && timeout_hit) |=> (tflag_q && bitpos_q == BITPOS_MSB && partial_q == '0))
    else $error("sync loss did not discard partial byte");
`endif

endmodule

// ----- tb/pwm_line_bit_receiver_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_line_bit_receiver_test
// Drives line samples into the PWM bit receiver and tracks pulse widths,
// bit decisions, byte assembly and sync-loss timeouts in a local model.
// Every result transfer is checked against the oldest predicted report.
// Directed pulse trains run first, then randomized phases of pulse-coded
// bytes, partial bytes and noise under varying thresholds and polarity.
// ----------------------------------------------------------------------------
module pwm_line_bit_receiver_test;
  import plbr_pkg::*;

  localparam int unsigned TCW          = 24;
  localparam int          RANDOM_ITEMS = 1750;
  localparam int          SETTLE       = 8;
  localparam int          CYCLE_LIMIT  = 3000000;
  localparam int          STALL_CYCLES = 200;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              sync_lost;
  } rx_report_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  plbr_in_if  sample_if ();
  plbr_out_if result_if ();

  pwm_line_bit_receiver #(
    .TICK_COUNT_WIDTH(TCW)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .sample_i   (sample_if),
    .result_o   (result_if)
  );

  // register copies
  logic              pol_q  = ACTIVE_LEVEL_RST;
  logic [HALF_W-1:0] half_q = HALF_BIT_RST;
  logic [TMO_W-1:0]  tmo_q  = TIMEOUT_RST;

  // receiver state copies
  logic                was_on      = 1'b0;
  logic [TCW-1:0]      ticks       = '1;
  logic [BYTE_W-1:0]   shreg       = '0;
  logic [BITPOS_W-1:0] pos         = BITPOS_MSB;
  logic                report_done = 1'b1;

  rx_report_t pending_reports_q[$];
  logic       line_level_q[$];

  int unsigned cycle_cnt         = 0;
  int          mismatches        = 0;
  int          pushed_total      = 0;
  bit          sample_taken      = 1'b0;
  bit          calm              = 1'b0;
  bit          stall_req         = 1'b0;
  bit          stall_done        = 1'b0;
  int          send_gap          = 0;
  int          recv_gap          = 0;
  int          hold_left         = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic track_line_sample(input logic lvl);
    logic       on;
    logic       bitv;
    logic       emitted;
    rx_report_t rep;
    on      = (lvl == pol_q);
    emitted = 1'b0;
    if (on && !was_on) begin
      ticks       = '0;
      report_done = 1'b0;
    end else if (ticks != '1) begin
      ticks = ticks + 1'b1;
    end
    if (!on && was_on) begin
      bitv       = (ticks > half_q);
      shreg[pos] = bitv;
      if (pos != BITPOS_LSB) begin
        pos = pos - 1'b1;
      end else begin
        rep.rx_byte   = shreg;
        rep.sync_lost = 1'b0;
        pending_reports_q.push_back(rep);
        shreg   = '0;
        pos     = BITPOS_MSB;
        emitted = 1'b1;
      end
    end
    if (!emitted && !report_done && ticks > tmo_q) begin
      shreg         = '0;
      pos           = BITPOS_MSB;
      report_done   = 1'b1;
      rep.rx_byte   = '0;
      rep.sync_lost = 1'b1;
      pending_reports_q.push_back(rep);
    end
    was_on = on;
  endtask

  // sample transfers feed the model, result transfers are checked
  always @(posedge clk_i) begin
    rx_report_t exp_rep;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (pending_reports_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual rx_byte %02h sync_lost %0b",
                   $time, result_if.rx_byte, result_if.sync_lost);
          mismatches++;
        end else begin
          exp_rep = pending_reports_q.pop_front();
          if (result_if.rx_byte !== exp_rep.rx_byte) begin
            $display("%0t: rx_byte mismatch, expected %02h, actual %02h",
                     $time, exp_rep.rx_byte, result_if.rx_byte);
            mismatches++;
          end
          if (result_if.sync_lost !== exp_rep.sync_lost) begin
            $display("%0t: sync_lost mismatch, expected %0b, actual %0b",
                     $time, exp_rep.sync_lost, result_if.sync_lost);
            mismatches++;
          end
        end
      end
      sample_taken = sample_if.valid && sample_if.ready;
      if (sample_taken) begin
        track_line_sample(sample_if.line_level);
      end
    end
  end

  // sample driver
  always @(negedge clk_i) begin
    logic nxt_valid;
    logic nxt_lvl;
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
    end else begin
      nxt_valid = sample_if.valid;
      nxt_lvl   = sample_if.line_level;
      if (!sample_if.valid || sample_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          nxt_valid = 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap  = $urandom_range(0, 2);
          nxt_valid = 1'b0;
        end else if (line_level_q.size() != 0) begin
          nxt_valid = 1'b1;
          nxt_lvl   = line_level_q.pop_front();
        end else begin
          nxt_valid = 1'b0;
        end
      end
      sample_if.valid      <= nxt_valid;
      sample_if.line_level <= nxt_lvl;
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else if (stall_req && !stall_done && result_if.valid) begin
      stall_done = 1'b1;
      hold_left  = STALL_CYCLES - 1;
      result_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      result_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(0, 2);
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ACTIVE_LEVEL: pol_q  = data[0];
      CFG_HALF_BIT:     half_q = data[HALF_W-1:0];
      CFG_TIMEOUT:      tmo_q  = data[TMO_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic pol, input logic [HALF_W-1:0] half,
                          input logic [TMO_W-1:0] tmo);
    write_reg(CFG_ACTIVE_LEVEL, CFG_DATA_W'(pol));
    write_reg(CFG_HALF_BIT, CFG_DATA_W'(half));
    write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
  endtask

  task automatic push_run(input logic lvl, input int n);
    repeat (n) begin
      line_level_q.push_back(lvl);
      pushed_total++;
    end
  endtask

  task automatic push_pulse(input int on_len, input int off_len);
    push_run(pol_q, on_len);
    push_run(~pol_q, off_len);
  endtask

  // exact: pulse widths sit right at the short/long boundary
  task automatic push_byte(input logic [7:0] value, input bit exact);
    int on_len;
    for (int i = 7; i >= 0; i--) begin
      if (value[i]) begin
        on_len = exact ? half_q + 1 : half_q + 1 + $urandom_range(0, half_q);
      end else begin
        on_len = exact ? half_q : $urandom_range(1, (half_q > 0) ? half_q : 1);
      end
      push_pulse(on_len, exact ? 1 : $urandom_range(1, 3));
    end
  endtask

  task automatic drain();
    while (line_level_q.size() != 0 || sample_if.valid || pending_reports_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    int               rand_base;
    int               segs;
    int               pick;
    bit               first;
    logic [HALF_W-1:0] h;
    logic [TMO_W-1:0]  t;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_ACTIVE_LEVEL;
    cfg_wdata_i          = '0;
    sample_if.valid      = 1'b0;
    sample_if.line_level = 1'b0;
    result_if.ready      = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: long and short pulse around the default threshold
    push_run(1'b0, 3);
    push_pulse(13, 2);
    push_pulse(12, 2);
    drain();

    // boundary-width bytes, idle timeout, timeout with line stuck active
    set_regs(1'b1, 16'd2, 24'd40);
    push_run(~pol_q, 45);
    push_byte(8'hA5, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    repeat (3) push_pulse(3, 1);
    push_run(~pol_q, 45);
    repeat (2) push_pulse(2, 1);
    push_pulse(45, 2);
    drain();

    // byte completes on the tick the timeout expires
    set_regs(1'b1, 16'd1, 24'd4);
    push_pulse(1, 6);
    repeat (7) push_pulse(1, 1);
    push_pulse(5, 3);
    drain();

    // zero threshold and zero timeout
    set_regs(1'b1, 16'd0, 24'd0);
    repeat (3) push_pulse(1, 1);
    push_pulse(2, 1);
    drain();

    // polarity flips while the line holds its level
    write_reg(CFG_ACTIVE_LEVEL, CFG_DATA_W'(1'b0));
    write_reg(CFG_HALF_BIT, CFG_DATA_W'(16'd2));
    write_reg(CFG_TIMEOUT, CFG_DATA_W'(24'd30));
    push_byte(8'h3C, 1'b0);
    push_run(1'b1, 2);
    drain();
    write_reg(CFG_ACTIVE_LEVEL, CFG_DATA_W'(1'b1));
    push_run(1'b1, 3);
    push_run(1'b0, 35);
    drain();

    // largest threshold and timeout
    set_regs(1'b1, 16'hFFFF, 24'hFFFFFF);
    push_pulse(3, 2);
    push_pulse(2, 2);
    drain();

    rand_base   = pushed_total;
    first       = 1'b1;
    while ((pushed_total - rand_base) < RANDOM_ITEMS) begin
      h = HALF_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 5));
      if (first || $urandom_range(0, 3) != 0) begin
        t = TMO_W'($urandom_range(2 * h + 6, 2 * h + 120));
      end else begin
        t = TMO_W'($urandom_range(0, 2 * h + 2));
      end
      set_regs(1'($urandom_range(0, 1)), h, t);
      if ((pushed_total - rand_base) > RANDOM_ITEMS * 4 / 5) calm = 1'b1;
      if (first) stall_req = 1'b1;
      segs = first ? 10 : $urandom_range(3, 8);
      repeat (segs) begin
        pick = $urandom_range(0, 9);
        if (first || pick < 7) begin
          push_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (pick < 9) begin
          repeat ($urandom_range(1, 7)) begin
            push_pulse($urandom_range(1, 2 * h + 1), $urandom_range(1, 3));
          end
          push_run((pick == 7) ? ~pol_q : pol_q, t + $urandom_range(1, 4));
          push_run(~pol_q, 2);
        end else begin
          repeat ($urandom_range(1, 20)) push_run(1'($urandom_range(0, 1)), 1);
        end
      end
      drain();
      first = 1'b0;
    end

    drain();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/plbr_pkg.sv
hw/rtl/plbr_if.sv
hw/rtl/pwm_line_bit_receiver.sv
tb/pwm_line_bit_receiver_test.sv
